### sv/brq_pkg.sv
// types and codes shared by the bounded request queue
`timescale 1ns / 1ps
`default_nettype none

package brq_pkg;

  // operation codes of an input word
  typedef enum logic [1:0] {
    OP_ENQ    = 2'd0,
    OP_DEQ    = 2'd1,
    OP_DROP   = 2'd2,
    OP_REMOVE = 2'd3
  } brq_op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } brq_status_e;

  // what a result word hands out
  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_DELIVERED = 2'd1,
    ACT_CLOSED    = 2'd2
  } brq_action_e;

  localparam logic [6:0] CAPACITY_RESET = 7'd64;

  typedef struct packed {
    brq_op_e     opcode;
    logic [15:0] req_fd;
    logic [31:0] req_time;
    logic [5:0]  position;
  } brq_in_t;

  typedef struct packed {
    brq_status_e status;
    brq_action_e action;
    logic [15:0] out_fd;
    logic [31:0] out_time;
    logic [6:0]  occupancy;
  } brq_out_t;

  // one stored request
  typedef struct packed {
    logic [15:0] fd;
    logic [31:0] tstamp;
  } brq_entry_t;

endpackage

`default_nettype wire

### sv/bounded_request_queue_with_drops.sv
// bounded request queue held as a ring in one synchronous memory
// result: enqueue and failed steps give their result word in the cycle after acceptance;
//   dequeue, drop-oldest and remove-at-index give it once the registered memory read returns
// throughput: enqueue one word per cycle while results are taken; dequeue and drop-oldest
//   take no new word while the entry read is pending; remove-at-index then compacts the newer
//   entries over the removed one, one memory move per cycle (one read and one write port)
// reset: queue empty, head at slot 0, capacity 64; the memory itself is not cleared
`timescale 1ns / 1ps
`default_nettype none

module bounded_request_queue_with_drops #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [6:0]      cfg_data_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire brq_pkg::brq_in_t  in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output brq_pkg::brq_out_t    out_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > 7) ? CW : 7;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_READ  = 3'b010,
    S_SHIFT = 3'b100
  } state_e;

  // ring successor of a slot
  function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
    nxt = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  state_e                state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [PW-1:0]         head_q, head_d;
  logic [6:0]            cap_q;
  logic                  out_valid_q, out_valid_d;
  brq_pkg::brq_out_t     out_data_q, out_data_d;
  brq_pkg::brq_action_e  act_q, act_d;
  logic [5:0]            left_q, left_d;
  logic [PW-1:0]         wr_q, wr_d;
  logic [PW-1:0]         rd_ptr_q;

  logic                  mem_we;
  logic [PW-1:0]         mem_wa;
  logic [PW-1:0]         mem_ra;
  brq_pkg::brq_entry_t   mem_wd;
  brq_pkg::brq_entry_t   mem_rd_q;
  brq_pkg::brq_entry_t   mem_q [DEPTH];

  logic                  accept;
  logic [XW-1:0]         cnt_x, pos_x, cap_x;
  logic                  full;
  logic [PW-1:0]         lslot;
  logic [PW:0]           idx_sum, tail_sum;
  logic [PW-1:0]         idx_phys, tail_phys;

  // handshake
  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // limit check and slot arithmetic
  assign cnt_x = XW'(cnt_q);
  assign pos_x = XW'(in_data_i.position);
  assign cap_x = XW'(cap_q);
  assign full  = (cnt_x >= cap_x) || (cnt_x >= XW'(DEPTH));

  assign lslot     = PW'(cnt_x - XW'(1) - pos_x);
  assign idx_sum   = (PW+1)'(head_q) + (PW+1)'(lslot);
  assign idx_phys  = (idx_sum >= (PW+1)'(DEPTH)) ? PW'(idx_sum - (PW+1)'(DEPTH))
                                                 : PW'(idx_sum);
  assign tail_sum  = (PW+1)'(head_q) + (PW+1)'(cnt_q);
  assign tail_phys = (tail_sum >= (PW+1)'(DEPTH)) ? PW'(tail_sum - (PW+1)'(DEPTH))
                                                  : PW'(tail_sum);

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    head_d      = head_q;
    act_d       = act_q;
    left_d      = left_q;
    wr_d        = wr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_wa      = wr_q;
    mem_wd      = mem_rd_q;
    mem_ra      = nxt(rd_ptr_q);

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_data_d = '{status: brq_pkg::ST_OK, action: brq_pkg::ACT_NONE,
                         out_fd: '0, out_time: '0, occupancy: 7'(cnt_q)};
          unique case (in_data_i.opcode) inside
            brq_pkg::OP_ENQ: begin
              out_valid_d = 1'b1;
              if (full) begin
                out_data_d.status = brq_pkg::ST_FULL;
              end else begin
                mem_we               = 1'b1;
                mem_wa               = tail_phys;
                mem_wd               = '{fd: in_data_i.req_fd, tstamp: in_data_i.req_time};
                cnt_d                = cnt_q + 1'b1;
                out_data_d.occupancy = 7'(cnt_q + 1'b1);
              end
            end
            brq_pkg::OP_DEQ, brq_pkg::OP_DROP, brq_pkg::OP_REMOVE: begin
              if (cnt_q == '0) begin
                out_valid_d       = 1'b1;
                out_data_d.status = brq_pkg::ST_EMPTY;
              end else if (in_data_i.opcode == brq_pkg::OP_REMOVE && pos_x >= cnt_x) begin
                out_valid_d       = 1'b1;
                out_data_d.status = brq_pkg::ST_RANGE;
              end else begin
                // fetch the leaving entry, result follows once the read returns
                cnt_d   = cnt_q - 1'b1;
                state_d = S_READ;
                if (in_data_i.opcode == brq_pkg::OP_REMOVE) begin
                  mem_ra = idx_phys;
                  act_d  = brq_pkg::ACT_CLOSED;
                  left_d = in_data_i.position;
                end else begin
                  mem_ra = head_q;
                  head_d = nxt(head_q);
                  act_d  = (in_data_i.opcode == brq_pkg::OP_DEQ) ? brq_pkg::ACT_DELIVERED
                                                                 : brq_pkg::ACT_CLOSED;
                  left_d = '0;
                end
              end
            end
          endcase
        end
      end
      S_READ: begin
        out_valid_d = 1'b1;
        out_data_d  = '{status: brq_pkg::ST_OK, action: act_q, out_fd: mem_rd_q.fd,
                        out_time: mem_rd_q.tstamp, occupancy: 7'(cnt_q)};
        wr_d        = rd_ptr_q;
        state_d     = (left_q == '0) ? S_IDLE : S_SHIFT;
      end
      S_SHIFT: begin
        // move the next newer entry down by one slot
        mem_we = 1'b1;
        wr_d   = nxt(wr_q);
        left_d = left_q - 1'b1;
        if (left_q == 6'd1) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      head_q      <= '0;
      cap_q       <= brq_pkg::CAPACITY_RESET;
      out_valid_q <= 1'b0;
      left_q      <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
      left_q      <= left_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    act_q      <= act_d;
    wr_q       <= wr_d;
    rd_ptr_q   <= mem_ra;
  end

  // entry memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    mem_rd_q <= mem_q[mem_ra];
  end

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (XW'(cnt_q) <= XW'(DEPTH)))
    else $error("entry count beyond depth");

  a_read_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |=> out_valid_q)
    else $error("no result word after entry read");

  a_shift_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (left_q != '0))
    else $error("compaction running with nothing left to move");

  a_enq_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.opcode == brq_pkg::OP_ENQ && !full)
      |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("enqueue did not grow the queue");

endmodule

`default_nettype wire

### test/bounded_request_queue_with_drops_test.sv
// self-checking testbench for the bounded request queue with drops
`timescale 1ns / 1ps

module bounded_request_queue_with_drops_test;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 400;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [6:0]          cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  brq_pkg::brq_in_t    in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  brq_pkg::brq_out_t   out_data_o;

  // words waiting to be offered, and results owed by the queue
  brq_pkg::brq_in_t    pending_words[$];
  brq_pkg::brq_out_t   owed_results[$];

  // shadow of the queue contents, oldest first, and of the capacity register
  brq_pkg::brq_entry_t waiting[$];
  logic [6:0]          capacity_now = brq_pkg::CAPACITY_RESET;

  // occupancy as the stimulus generator sees it
  int unsigned gen_count = 0;

  int unsigned send_idle_pct = 16;
  int unsigned recv_idle_pct = 84;
  logic        hold_start = 1'b0;
  logic        hold_taken = 1'b0;
  int unsigned hold_left = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_cnt = 0;

  bounded_request_queue_with_drops #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // work out the result of one accepted word and update the shadow queue
  function automatic brq_pkg::brq_out_t serve_request(input brq_pkg::brq_in_t w);
    brq_pkg::brq_out_t r;
    int unsigned       lim;
    int unsigned       slot;
    r = '0;
    r.status = brq_pkg::ST_OK;
    r.action = brq_pkg::ACT_NONE;
    lim = (capacity_now > DEPTH) ? DEPTH : capacity_now;
    if (w.opcode == brq_pkg::OP_ENQ) begin
      if (waiting.size() >= lim) begin
        r.status = brq_pkg::ST_FULL;
      end else begin
        waiting.push_back('{fd: w.req_fd, tstamp: w.req_time});
      end
    end else if (waiting.size() == 0) begin
      r.status = brq_pkg::ST_EMPTY;
    end else if (w.opcode == brq_pkg::OP_REMOVE && w.position >= waiting.size()) begin
      r.status = brq_pkg::ST_RANGE;
    end else begin
      // position counts from the newest entry
      slot = (w.opcode == brq_pkg::OP_REMOVE) ? waiting.size() - 1 - w.position : 0;
      r.action = (w.opcode == brq_pkg::OP_DEQ) ? brq_pkg::ACT_DELIVERED
                                               : brq_pkg::ACT_CLOSED;
      r.out_fd = waiting[slot].fd;
      r.out_time = waiting[slot].tstamp;
      waiting.delete(slot);
    end
    r.occupancy = 7'(waiting.size());
    return r;
  endfunction

  task automatic show_mismatch(input string field, input longint unsigned exp_v,
                               input longint unsigned got_v);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v, got_v);
  endtask

  // compare one result word with the oldest owed result
  task automatic check_result(input brq_pkg::brq_out_t got);
    brq_pkg::brq_out_t exp_r;
    if (owed_results.size() == 0) begin
      $display("%0t: unexpected result word, expected none, got %h", $time, got);
      fail_count++;
    end else begin
      exp_r = owed_results.pop_front();
      if (got !== exp_r) begin
        fail_count++;
        if (got.status !== exp_r.status)
          show_mismatch("status", exp_r.status, got.status);
        if (got.action !== exp_r.action)
          show_mismatch("action", exp_r.action, got.action);
        if (got.out_fd !== exp_r.out_fd)
          show_mismatch("out_fd", exp_r.out_fd, got.out_fd);
        if (got.out_time !== exp_r.out_time)
          show_mismatch("out_time", exp_r.out_time, got.out_time);
        if (got.occupancy !== exp_r.occupancy)
          show_mismatch("occupancy", exp_r.occupancy, got.occupancy);
      end
    end
  endtask

  // driver: predict on acceptance, then offer the next word or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        owed_results.push_back(serve_request(in_data_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_words.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: check result words, stall at random or for one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        check_result(out_data_o);
      end
      if (hold_start && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("bounded_request_queue_with_drops_test: FAIL");
      $finish;
    end
  end

  // append one word and track the occupancy it leaves
  task automatic queue_word(input brq_pkg::brq_op_e op, input logic [15:0] fd,
                            input logic [31:0] ts, input logic [5:0] pos);
    brq_pkg::brq_in_t w;
    int unsigned      lim;
    w.opcode = op;
    w.req_fd = fd;
    w.req_time = ts;
    w.position = pos;
    pending_words.push_back(w);
    lim = (capacity_now > DEPTH) ? DEPTH : capacity_now;
    case (op) inside
      brq_pkg::OP_ENQ: if (gen_count < lim) gen_count++;
      brq_pkg::OP_DEQ, brq_pkg::OP_DROP: if (gen_count > 0) gen_count--;
      default: if (pos < gen_count) gen_count--;
    endcase
  endtask

  // wait until every word is through and the block has settled
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_words.size() != 0 || in_valid_i || owed_results.size() != 0);
    repeat (DEPTH + 8) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [6:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    capacity_now = value;
    @(negedge clk_i);
  endtask

  // one random phase at a given capacity and idling mix
  task automatic run_phase(input logic [6:0] cap, input int unsigned n,
                           input int unsigned enq_pct, input int unsigned s_idle,
                           input int unsigned r_idle, input logic hold);
    brq_pkg::brq_op_e op;
    logic [5:0]       pos;
    wait_idle();
    write_capacity(cap);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (n) begin
      if ($urandom_range(0, 99) < enq_pct) begin
        op = brq_pkg::OP_ENQ;
      end else begin
        case ($urandom_range(0, 2))
          0: op = brq_pkg::OP_DEQ;
          1: op = brq_pkg::OP_DROP;
          default: op = brq_pkg::OP_REMOVE;
        endcase
      end
      // mostly hit a live entry, sometimes any position
      if (op == brq_pkg::OP_REMOVE && gen_count != 0 && $urandom_range(0, 9) < 8)
        pos = 6'($urandom_range(0, gen_count - 1));
      else
        pos = 6'($urandom_range(0, 63));
      queue_word(op, 16'($urandom), $urandom, pos);
    end
    if (hold) hold_start = 1'b1;
  endtask

  // stimulus
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // removals from an empty queue
    queue_word(brq_pkg::OP_DEQ, 16'hffff, 32'hffffffff, 6'h3f);
    queue_word(brq_pkg::OP_DROP, 16'h0000, 32'h0, 6'h00);
    queue_word(brq_pkg::OP_REMOVE, 16'h0000, 32'h0, 6'h00);
    queue_word(brq_pkg::OP_REMOVE, 16'hffff, 32'hffffffff, 6'h3f);
    // field extremes on enqueue, position ignored
    queue_word(brq_pkg::OP_ENQ, 16'h0000, 32'h00000000, 6'h3f);
    queue_word(brq_pkg::OP_ENQ, 16'hffff, 32'hffffffff, 6'h00);
    queue_word(brq_pkg::OP_ENQ, 16'h1234, 32'h00000005, 6'h15);
    queue_word(brq_pkg::OP_ENQ, 16'ha5a5, 32'h5a5a5a5a, 6'h2a);
    queue_word(brq_pkg::OP_ENQ, 16'h5a5a, 32'ha5a5a5a5, 6'h3f);
    // positions at and beyond the count
    queue_word(brq_pkg::OP_REMOVE, 16'h0, 32'h0, 6'h3f);
    queue_word(brq_pkg::OP_REMOVE, 16'h0, 32'h0, 6'd5);
    // oldest, newest and a middle entry
    queue_word(brq_pkg::OP_REMOVE, 16'hffff, 32'hffffffff, 6'd4);
    queue_word(brq_pkg::OP_REMOVE, 16'h0, 32'h0, 6'd0);
    queue_word(brq_pkg::OP_REMOVE, 16'h0, 32'h0, 6'd1);
    // plain dequeue and drop down to empty
    queue_word(brq_pkg::OP_DEQ, 16'hffff, 32'hffffffff, 6'h3f);
    queue_word(brq_pkg::OP_DROP, 16'hffff, 32'hffffffff, 6'h3f);
    queue_word(brq_pkg::OP_DEQ, 16'h0, 32'h0, 6'h0);
    queue_word(brq_pkg::OP_ENQ, 16'h8001, 32'h80000001, 6'h00);
    queue_word(brq_pkg::OP_ENQ, 16'h7ffe, 32'h7ffffffe, 6'h00);
    queue_word(brq_pkg::OP_DROP, 16'h0, 32'h0, 6'h0);
    queue_word(brq_pkg::OP_DEQ, 16'h0, 32'h0, 6'h0);

    // sender idles a little, receiver a lot
    run_phase(7'd64, 120, 75, 16, 84, 1'b0);
    run_phase(7'd1, 60, 50, 16, 84, 1'b0);
    run_phase(7'd0, 30, 50, 16, 84, 1'b0);
    // receiver idles a little, sender a lot
    run_phase(7'd127, 130, 80, 84, 16, 1'b0);
    run_phase(7'd4, 80, 55, 84, 16, 1'b0);
    // no idling, with one long receiver hold-off
    run_phase(7'd64, 120, 60, 0, 0, 1'b1);
    run_phase(7'($urandom_range(2, 63)), 140, 50, 0, 0, 1'b0);

    wait_idle();
    if (fail_count == 0) begin
      $display("bounded_request_queue_with_drops_test: PASS");
    end else begin
      $display("bounded_request_queue_with_drops_test: FAIL");
    end
    $finish;
  end

endmodule
